@@ hw/rtl/json_shape_checker_top_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef JSON_SHAPE_CHECKER_TOP_MACROS_SVH
`define JSON_SHAPE_CHECKER_TOP_MACROS_SVH

// Property that holds whenever reset is low: the consequent follows the antecedent.
`define JSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Property that is checked in every cycle, reset included: the consequent holds in the cycle after the antecedent.
`define JSC_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/jsc_pkg.sv @@
`default_nettype none

package jsc_pkg;

   // Width of the brace and bracket nesting counters.
   localparam int DEPTH_BITS = 16;

   typedef logic [7:0]            char_type;
   typedef logic [DEPTH_BITS-1:0] depth_type;
   typedef logic [1:0]            nonblank_type;

   localparam depth_type    DEPTH_MAX     = '1;
   localparam nonblank_type NONBLANK_NONE = 2'd0;
   localparam nonblank_type NONBLANK_TWO  = 2'd2;

   // Characters that the shape check looks at.
   localparam char_type CHAR_SPACE     = 8'h20;
   localparam char_type CHAR_TAB       = 8'h09;
   localparam char_type CHAR_LF        = 8'h0A;
   localparam char_type CHAR_CR        = 8'h0D;
   localparam char_type CHAR_LBRACE    = 8'h7B;
   localparam char_type CHAR_RBRACE    = 8'h7D;
   localparam char_type CHAR_LBRACKET  = 8'h5B;
   localparam char_type CHAR_RBRACKET  = 8'h5D;
   localparam char_type CHAR_COLON     = 8'h3A;
   localparam char_type CHAR_BACKSLASH = 8'h5C;
   localparam char_type CHAR_QUOTE     = 8'h22;

   // Tracking state carried from one item to the next within a text.
   typedef struct packed {
      logic         inside_string;
      logic         escape_pending;
      logic         colon_seen;
      logic         failed;
      logic         overflow;
      depth_type    brace_depth;
      depth_type    bracket_depth;
      char_type     opening_char;
      char_type     closing_char;
      nonblank_type nonblank_count;
   } shape_state_type;

   function automatic logic is_blank(input char_type c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/jsc_ifs.sv @@
`default_nettype none

// Input channel: one text byte per item, with a flag on the final byte.
interface jsc_req_if import jsc_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type data_byte;
   logic     end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

// Result channel: one verdict item per text.
interface jsc_rsp_if ();
   logic valid;
   logic ready;
   logic looks_like_json;
   logic depth_overflow;

   modport source (output valid, output looks_like_json, output depth_overflow, input ready);
   modport sink (input valid, input looks_like_json, input depth_overflow, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/json_shape_checker_top.sv @@
`default_nettype none

// Streaming JSON shape check. The text enters one byte per item on req_chan, with
// end_of_text set on its final byte, and exactly one verdict item leaves on rsp_chan
// for each text. The verdict says whether the outer non-blank bytes form a matching
// brace or bracket pair, whether nesting outside strings stays balanced and never goes
// negative, whether strings are closed, and whether an object holds a colon;
// depth_overflow reports that a nesting counter saturated at jsc_pkg::DEPTH_BITS bits.
// The block takes one byte per clock cycle while its input is not stalled. A byte is held
// in an input register, then a single state-update stage folds it into the tracking
// state and, for a final byte, into the result register that shows the verdict. Input
// stalls only while a verdict is waiting in the result register and the next final byte
// reaches the update stage.
module json_shape_checker_top import jsc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   jsc_req_if.sink   req_chan,
   jsc_rsp_if.source rsp_chan
);

   logic            stage_valid_ff;
   char_type        stage_byte_ff;
   logic            stage_last_ff;
   shape_state_type state_ff;
   shape_state_type state_in;
   shape_state_type st;
   logic            rsp_valid_ff;
   logic            rsp_json_ff;
   logic            rsp_ovf_ff;
   logic            verdict_in;
   logic            advance;

   // The staged item moves on unless it is a final byte and the result register is full and not being taken.
   assign advance = stage_valid_ff && (!stage_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;

   // Fold the staged byte into the tracking state and form the verdict.
   always_comb begin
      st = state_ff;
      if (!is_blank(stage_byte_ff)) begin
         if (st.nonblank_count == NONBLANK_NONE) begin
            st.opening_char = stage_byte_ff;
         end
         st.closing_char = stage_byte_ff;
         if (st.nonblank_count != NONBLANK_TWO) begin
            st.nonblank_count = st.nonblank_count + nonblank_type'(1);
         end
      end
      if ((st.nonblank_count != NONBLANK_NONE) && !state_ff.failed) begin
         priority if (st.escape_pending) begin
            st.escape_pending = 1'b0;
         end else if (stage_byte_ff == CHAR_BACKSLASH) begin
            if (st.inside_string) begin
               st.escape_pending = 1'b1;
            end
         end else if (stage_byte_ff == CHAR_QUOTE) begin
            st.inside_string = !st.inside_string;
         end else if (!st.inside_string) begin
            priority if (stage_byte_ff == CHAR_LBRACE) begin
               if (st.brace_depth == DEPTH_MAX) begin
                  st.overflow = 1'b1;
               end else begin
                  st.brace_depth = st.brace_depth + depth_type'(1);
               end
            end else if (stage_byte_ff == CHAR_RBRACE) begin
               if (st.brace_depth == '0) begin
                  st.failed = 1'b1;
               end else begin
                  st.brace_depth = st.brace_depth - depth_type'(1);
               end
            end else if (stage_byte_ff == CHAR_LBRACKET) begin
               if (st.bracket_depth == DEPTH_MAX) begin
                  st.overflow = 1'b1;
               end else begin
                  st.bracket_depth = st.bracket_depth + depth_type'(1);
               end
            end else if (stage_byte_ff == CHAR_RBRACKET) begin
               if (st.bracket_depth == '0) begin
                  st.failed = 1'b1;
               end else begin
                  st.bracket_depth = st.bracket_depth - depth_type'(1);
               end
            end else if (stage_byte_ff == CHAR_COLON) begin
               st.colon_seen = 1'b1;
            end else begin
               st.colon_seen = st.colon_seen;
            end
         end else begin
            st.inside_string = 1'b1;
         end
      end

      verdict_in = (st.nonblank_count == NONBLANK_TWO)
         && (((st.opening_char == CHAR_LBRACE) && (st.closing_char == CHAR_RBRACE))
            || ((st.opening_char == CHAR_LBRACKET) && (st.closing_char == CHAR_RBRACKET)))
         && !st.failed && !st.overflow
         && (st.brace_depth == '0) && (st.bracket_depth == '0) && !st.inside_string
         && !((st.opening_char == CHAR_LBRACE) && !st.colon_seen);

      // Everything clears once the final byte of a text has been folded in.
      state_in = stage_last_ff ? '0 : st;
   end

   // Control state: stage occupancy, tracking state and result occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         state_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            stage_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && stage_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers of the input stage and the result.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         stage_byte_ff <= req_chan.data_byte;
         stage_last_ff <= req_chan.end_of_text;
      end
      if (advance && stage_last_ff) begin
         rsp_json_ff <= verdict_in;
         rsp_ovf_ff  <= st.overflow;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.looks_like_json = rsp_json_ff;
   assign rsp_chan.depth_overflow  = rsp_ovf_ff;

endmodule

`default_nettype wire

@@ hw/rtl/jsc_checker.sv @@
`default_nettype none

`include "json_shape_checker_top_macros.svh"

// Checks on the result port of the shape checker.
module jsc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_json,
   input wire logic rsp_ovf
);

   // Reset leaves no verdict pending.
   `JSC_ASSERT_NEXT(a_reset_clears_rsp, clock, reset, !rsp_valid, "verdict valid after reset")

   // A saturated counter always forces a failing verdict.
   `JSC_ASSERT_IMPL(a_ovf_fails, clock, reset, rsp_valid && rsp_ovf, !rsp_json, "passing verdict with overflow")

   // A stalled verdict stays put until it is taken.
   `JSC_ASSERT_IMPL(a_rsp_hold, clock, reset, $past(rsp_valid && !rsp_ready) && !$past(reset), rsp_valid && $stable(rsp_json) && $stable(rsp_ovf), "stalled verdict changed")

endmodule

bind json_shape_checker_top jsc_checker u_jsc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_json  (rsp_chan.looks_like_json),
   .rsp_ovf   (rsp_chan.depth_overflow)
);

`default_nettype wire

@@ dv/json_shape_verdict_checker.sv @@
// Watches both channels of the JSON shape checker, keeps its own copy of the
// tracking state, and compares every verdict item with the oldest prediction.
module json_shape_verdict_checker import jsc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_ready,
   input  char_type req_data_byte,
   input  logic     req_end_of_text,
   input  logic     rsp_valid,
   input  logic     rsp_ready,
   input  logic     rsp_looks_like_json,
   input  logic     rsp_depth_overflow,
   output int       fail_count,
   output int       verdicts_pending,
   output int       bytes_seen,
   output int       verdicts_seen,
   output int       json_verdicts,
   output int       overflow_verdicts
);

   typedef struct packed {
      logic looks_like_json;
      logic depth_overflow;
   } verdict_type;

   // Verdicts predicted for finished texts, oldest first.
   verdict_type verdicts_due[$];

   // Predicted shape state of the text in flight.
   char_type     first_char;
   char_type     last_char;
   nonblank_type seen_count;
   depth_type    brace_lvl;
   depth_type    bracket_lvl;
   logic         in_str;
   logic         esc;
   logic         colon;
   logic         broken;
   logic         saturated;

   int mismatches;
   int n_bytes;
   int n_verdicts;
   int n_json;
   int n_overflow;

   task automatic clear_shape();
      first_char  = '0;
      last_char   = '0;
      seen_count  = NONBLANK_NONE;
      brace_lvl   = '0;
      bracket_lvl = '0;
      in_str      = 1'b0;
      esc         = 1'b0;
      colon       = 1'b0;
      broken      = 1'b0;
      saturated   = 1'b0;
   endtask

   // Folds one accepted byte into the shape state; on the final byte it
   // queues the verdict and starts over.
   task automatic fold_text_byte(input char_type c, input logic last);
      logic        blank;
      verdict_type v;
      blank = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
      if (!blank) begin
         if (seen_count == NONBLANK_NONE) begin
            first_char = c;
         end
         last_char = c;
         if (seen_count < NONBLANK_TWO) begin
            seen_count = seen_count + 1'b1;
         end
      end

      // Nesting, string and colon tracking freeze once depth went negative.
      if (seen_count != NONBLANK_NONE && !broken) begin
         if (esc) begin
            esc = 1'b0;
         end else if (c == CHAR_BACKSLASH) begin
            if (in_str) begin
               esc = 1'b1;
            end
         end else if (c == CHAR_QUOTE) begin
            in_str = !in_str;
         end else if (!in_str) begin
            case (c)
               CHAR_LBRACE: begin
                  if (brace_lvl == DEPTH_MAX) saturated = 1'b1;
                  else brace_lvl = brace_lvl + 1'b1;
               end
               CHAR_RBRACE: begin
                  if (brace_lvl == '0) broken = 1'b1;
                  else brace_lvl = brace_lvl - 1'b1;
               end
               CHAR_LBRACKET: begin
                  if (bracket_lvl == DEPTH_MAX) saturated = 1'b1;
                  else bracket_lvl = bracket_lvl + 1'b1;
               end
               CHAR_RBRACKET: begin
                  if (bracket_lvl == '0) broken = 1'b1;
                  else bracket_lvl = bracket_lvl - 1'b1;
               end
               CHAR_COLON: begin
                  colon = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end

      if (last) begin
         v.looks_like_json = (seen_count >= NONBLANK_TWO)
            && ((first_char == CHAR_LBRACE && last_char == CHAR_RBRACE)
                || (first_char == CHAR_LBRACKET && last_char == CHAR_RBRACKET))
            && !broken && !saturated
            && brace_lvl == '0 && bracket_lvl == '0 && !in_str
            && !(first_char == CHAR_LBRACE && !colon);
         v.depth_overflow = saturated;
         verdicts_due.push_back(v);
         clear_shape();
      end
   endtask

   always @(posedge clock) begin : watch
      verdict_type due;
      if (reset) begin
         verdicts_due.delete();
         clear_shape();
      end else begin
         // Check a verdict item against the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            n_verdicts++;
            if (rsp_looks_like_json) n_json++;
            if (rsp_depth_overflow) n_overflow++;
            if (verdicts_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected verdict item: looks_like_json=%0b depth_overflow=%0b",
                           rsp_looks_like_json, rsp_depth_overflow);
               end
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_looks_like_json !== due.looks_like_json
                   || rsp_depth_overflow !== due.depth_overflow) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("verdict %0d: expected json=%0b ovf=%0b, got %0b %0b",
                              n_verdicts, due.looks_like_json, due.depth_overflow,
                              rsp_looks_like_json, rsp_depth_overflow);
                  end
               end
            end
         end

         // Fold in each accepted text byte.
         if (req_valid && req_ready) begin
            n_bytes++;
            fold_text_byte(req_data_byte, req_end_of_text);
         end
      end

      fail_count        <= mismatches;
      verdicts_pending  <= verdicts_due.size();
      bytes_seen        <= n_bytes;
      verdicts_seen     <= n_verdicts;
      json_verdicts     <= n_json;
      overflow_verdicts <= n_overflow;
   end

endmodule

@@ dv/json_shape_checker_top_test.sv @@
// Drives texts into the JSON shape checker and stalls its verdict channel;
// the verdict checker beside the block does all the comparing.
module json_shape_checker_top_test;
   import jsc_pkg::*;

   logic clock;
   logic reset;

   jsc_req_if req_chan ();
   jsc_rsp_if rsp_chan ();

   int fail_count;
   int verdicts_pending;
   int bytes_seen;
   int verdicts_seen;
   int json_verdicts;
   int overflow_verdicts;

   // Idling on or off for the text being sent, per side.
   logic req_idle_on;
   logic rsp_idle_on;

   char_type text_q[$];
   int       random_items;

   json_shape_checker_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   json_shape_verdict_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_chan.valid),
      .req_ready           (req_chan.ready),
      .req_data_byte       (req_chan.data_byte),
      .req_end_of_text     (req_chan.end_of_text),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_looks_like_json (rsp_chan.looks_like_json),
      .rsp_depth_overflow  (rsp_chan.depth_overflow),
      .fail_count          (fail_count),
      .verdicts_pending    (verdicts_pending),
      .bytes_seen          (bytes_seen),
      .verdicts_seen       (verdicts_seen),
      .json_verdicts       (json_verdicts),
      .overflow_verdicts   (overflow_verdicts)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Sends one byte, after a random gap if idling is on, and returns at the edge that takes it.
   task automatic push_byte(input char_type b, input logic eot);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.data_byte   <= b;
      req_chan.end_of_text <= eot;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_text();
      foreach (text_q[k]) begin
         push_byte(text_q[k], k == text_q.size() - 1);
      end
   endtask

   task automatic add_blanks(input int n);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: text_q.push_back(CHAR_SPACE);
            1: text_q.push_back(CHAR_TAB);
            2: text_q.push_back(CHAR_LF);
            default: text_q.push_back(CHAR_CR);
         endcase
      end
   endtask

   // A byte that matters to the shape check, or now and then any byte.
   function automatic char_type pick_special();
      case ($urandom_range(0, 8))
         0: return CHAR_LBRACE;
         1: return CHAR_RBRACE;
         2: return CHAR_LBRACKET;
         3: return CHAR_RBRACKET;
         4: return CHAR_QUOTE;
         5: return CHAR_BACKSLASH;
         6: return CHAR_COLON;
         7: return CHAR_SPACE;
         default: return char_type'($urandom_range(0, 255));
      endcase
   endfunction

   // Builds a well-formed text: nested objects and arrays, strings with
   // escapes and arbitrary bytes, colons, commas, digits and blanks.
   task automatic build_shaped_text();
      char_type nest[$];
      char_type outer;
      char_type opener;
      char_type body;
      logic     colon_placed;
      text_q.delete();
      colon_placed = 1'b0;
      add_blanks($urandom_range(0, 2));
      outer = $urandom_range(0, 1) ? CHAR_LBRACE : CHAR_LBRACKET;
      text_q.push_back(outer);
      nest.push_back(outer);
      repeat ($urandom_range(0, 10)) begin
         case ($urandom_range(0, 6))
            0: begin
               if (nest.size() < 5) begin
                  opener = $urandom_range(0, 1) ? CHAR_LBRACE : CHAR_LBRACKET;
                  text_q.push_back(opener);
                  nest.push_back(opener);
               end
            end
            1: begin
               if (nest.size() > 1) begin
                  text_q.push_back(nest.pop_back() == CHAR_LBRACE ? CHAR_RBRACE
                                                                  : CHAR_RBRACKET);
               end
            end
            2: begin
               text_q.push_back(CHAR_QUOTE);
               repeat ($urandom_range(0, 4)) begin
                  body = $urandom_range(0, 3) == 0 ? pick_special()
                                                   : char_type'($urandom_range(0, 255));
                  if (body == CHAR_QUOTE || body == CHAR_BACKSLASH) begin
                     text_q.push_back(CHAR_BACKSLASH);
                  end
                  text_q.push_back(body);
               end
               text_q.push_back(CHAR_QUOTE);
            end
            3: begin
               text_q.push_back(CHAR_COLON);
               colon_placed = 1'b1;
            end
            4: text_q.push_back(8'h2C);
            5: add_blanks(1);
            default: text_q.push_back(char_type'($urandom_range(8'h30, 8'h39)));
         endcase
      end
      // Close what is still open; an object gets a colon if it lacks one.
      while (nest.size() > 0) begin
         if (nest.size() == 1 && outer == CHAR_LBRACE && !colon_placed) begin
            text_q.push_back(CHAR_COLON);
         end
         text_q.push_back(nest.pop_back() == CHAR_LBRACE ? CHAR_RBRACE : CHAR_RBRACKET);
      end
      add_blanks($urandom_range(0, 2));
   endtask

   // Response side: random stalls before each verdict item.
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 15) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin
      #10000000;
      $display("json_shape_checker_top: mismatch");
      $finish;
   end

   // Stimulus: directed texts, then random texts.
   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.data_byte   <= '0;
      req_chan.end_of_text <= 1'b0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      random_items = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Short directed texts covering each special case.
      text_q = '{CHAR_LBRACKET, CHAR_RBRACKET};
      send_text();
      text_q = '{CHAR_SPACE, CHAR_LBRACE, CHAR_COLON, CHAR_RBRACE, CHAR_TAB};
      send_text();
      text_q = '{CHAR_LBRACE, CHAR_RBRACE};
      send_text();
      // Blank text.
      text_q = '{CHAR_LF, CHAR_CR};
      send_text();
      // Escaped bracket inside a string.
      text_q = '{CHAR_LBRACKET, CHAR_QUOTE, CHAR_BACKSLASH, CHAR_RBRACKET, CHAR_QUOTE,
                 CHAR_RBRACKET};
      send_text();
      // Backslash outside a string and the extreme byte values.
      text_q = '{CHAR_LBRACKET, CHAR_BACKSLASH, 8'hFF, 8'h00, CHAR_RBRACKET};
      send_text();
      // Negative depth, then tracking stays frozen.
      text_q = '{CHAR_LBRACKET, CHAR_RBRACKET, CHAR_RBRACKET, CHAR_LBRACKET,
                 CHAR_RBRACKET};
      send_text();
      text_q = '{CHAR_LBRACE, CHAR_QUOTE, CHAR_RBRACE};
      send_text();
      text_q = '{CHAR_LBRACKET};
      send_text();

      // Random texts: mostly well formed, some damaged, some noise.
      while (random_items < 1750) begin
         req_idle_on = $urandom_range(0, 3) != 0;
         rsp_idle_on = $urandom_range(0, 3) != 0;
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               text_q.delete();
               repeat ($urandom_range(1, 12)) begin
                  text_q.push_back($urandom_range(0, 1) ? pick_special()
                                                        : char_type'($urandom_range(0, 255)));
               end
            end
            3, 4, 5: begin
               build_shaped_text();
               repeat ($urandom_range(1, 2)) begin
                  text_q[$urandom_range(0, text_q.size() - 1)] = pick_special();
               end
            end
            default: build_shaped_text();
         endcase
         send_text();
         random_items += text_q.size();
      end
      req_chan.valid <= 1'b0;

      // Drain the outstanding verdicts, then let the pipeline settle.
      do @(posedge clock); while (verdicts_pending != 0);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes; %0d verdicts checked, %0d judged JSON, %0d with saturation.",
               bytes_seen, verdicts_seen, json_verdicts, overflow_verdicts);
      $display("Texts: directed cases, then shaped, damaged and noise texts.");
      if (verdicts_pending != 0) begin
         $display("%0d predicted verdicts never arrived", verdicts_pending);
      end
      if (fail_count == 0 && verdicts_pending == 0) begin
         $display("json_shape_checker_top: match");
      end else begin
         $display("json_shape_checker_top: mismatch");
      end
      $finish;
   end

endmodule
